### rtl/core/lpsis_pkg.sv
// Shared constants, types and command codes for the scaled polygon interior sum.
// Used by every module of the block except lpsis_ram; depends on nothing.
package lpsis_pkg;

  localparam int unsigned MaxVertices = 1024;
  localparam int unsigned CoordBits   = 20;

  localparam int unsigned InCoordW = 20;
  localparam int unsigned ScaleW   = 17;
  localparam int unsigned TotalW   = 63;

  localparam int unsigned AddrW   = $clog2(MaxVertices);
  localparam int unsigned CntW    = $clog2(MaxVertices + 1);
  localparam int unsigned IdxW    = $clog2(MaxVertices + 3);
  localparam int unsigned VtxW    = 2 * CoordBits;
  localparam int unsigned CrossW  = 2 * (CoordBits + 1);
  localparam int unsigned ProdW   = 2 * CoordBits;
  localparam int unsigned AreaW   = 64;
  localparam int unsigned BndW    = 32;
  localparam int unsigned GcdW    = CoordBits;
  localparam int unsigned GcdKW   = $clog2(GcdW + 1);
  localparam int unsigned DivW    = 64;
  localparam int unsigned DivCntW = $clog2(DivW);
  localparam int unsigned QW      = AreaW + 2 * ScaleW;
  localparam int unsigned TW      = BndW + ScaleW;
  localparam int unsigned SumW    = 128;

  typedef struct packed {
    logic [CoordBits-1:0] x;
    logic [CoordBits-1:0] y;
  } vertex_t;

  typedef enum logic [4:0] {
    OP_NONE   = 5'd0,
    OP_CLEAR  = 5'd1,
    OP_SHIFT  = 5'd2,
    OP_CROSS  = 5'd3,
    OP_KEEP   = 5'd4,
    OP_CLOSE  = 5'd5,
    OP_EMUL   = 5'd6,
    OP_EACC   = 5'd7,
    OP_BND    = 5'd8,
    OP_GSTORE = 5'd9,
    OP_SQ     = 5'd10,
    OP_DIVA   = 5'd11,
    OP_A2     = 5'd12,
    OP_B      = 5'd13,
    OP_SINIT  = 5'd14,
    OP_S1     = 5'd15,
    OP_S2     = 5'd16,
    OP_S3     = 5'd17,
    OP_OUT    = 5'd18
  } dp_op_e;

  typedef struct packed {
    dp_op_e           op;
    logic             take_last;
    logic             wr_en;
    logic [AddrW-1:0] wr_addr;
    logic             rd_en;
    logic [AddrW-1:0] rd_addr;
  } ctrl_cmd_t;

  typedef struct packed {
    logic keep;
    logic have_first;
    logic g_zero;
    logic gcd_done;
    logic div_done;
    logic last_scale;
    logic scale_zero;
  } dp_status_t;

endpackage

### rtl/core/lpsis_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module lpsis_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/lpsis_gcd.sv
// Binary gcd unit, one reduction step per cycle.
// Depends on lpsis_pkg.
module lpsis_gcd (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [lpsis_pkg::GcdW-1:0] a_i,
  input  logic [lpsis_pkg::GcdW-1:0] b_i,
  output logic                       done_o,
  output logic [lpsis_pkg::GcdW-1:0] result_o
);

  logic [lpsis_pkg::GcdW-1:0]  a_q, b_q, result_q;
  logic [lpsis_pkg::GcdKW-1:0] k_q;
  logic                        run_q, done_q;
  logic                        finish;

  assign finish = (a_q == '0) || (b_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
    end else if (run_q && finish) begin
      run_q  <= 1'b0;
      done_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
      k_q <= '0;
    end else if (run_q) begin
      priority if (finish) begin
        result_q <= (a_q | b_q) << k_q;
      end else if (!a_q[0] && !b_q[0]) begin
        a_q <= a_q >> 1;
        b_q <= b_q >> 1;
        k_q <= k_q + 1'b1;
      end else if (!a_q[0]) begin
        a_q <= a_q >> 1;
      end else if (!b_q[0]) begin
        b_q <= b_q >> 1;
      end else if (a_q >= b_q) begin
        a_q <= (a_q - b_q) >> 1;
      end else begin
        b_q <= (b_q - a_q) >> 1;
      end
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

### rtl/core/lpsis_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on lpsis_pkg.
module lpsis_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [lpsis_pkg::DivW-1:0] dividend_i,
  input  logic [lpsis_pkg::DivW-1:0] divisor_i,
  output logic                       done_o,
  output logic [lpsis_pkg::DivW-1:0] quotient_o
);

  logic [lpsis_pkg::DivW-1:0]    dvd_q, dvs_q, rem_q;
  logic [lpsis_pkg::DivCntW-1:0] cnt_q;
  logic                          run_q, done_q;
  logic [lpsis_pkg::DivW:0]      rem_sh, rem_sub;
  logic                          ge;

  assign rem_sh  = {rem_q, dvd_q[lpsis_pkg::DivW-1]};
  assign ge      = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (run_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == lpsis_pkg::DivCntW'(lpsis_pkg::DivW - 1)) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (run_q) begin
      rem_q <= ge ? rem_sub[lpsis_pkg::DivW-1:0] : rem_sh[lpsis_pkg::DivW-1:0];
      dvd_q <= {dvd_q[lpsis_pkg::DivW-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

### rtl/core/lpsis_dp.sv
// Datapath: vertex store, turn test, shoelace and boundary accumulation, scaling sum.
// Depends on lpsis_pkg, lpsis_ram, lpsis_gcd, lpsis_div.
module lpsis_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  lpsis_pkg::ctrl_cmd_t           cmd_i,
  input  logic [lpsis_pkg::InCoordW-1:0] x_coord_i,
  input  logic [lpsis_pkg::InCoordW-1:0] y_coord_i,
  input  logic [lpsis_pkg::ScaleW-1:0]   scale_count_i,
  output lpsis_pkg::dp_status_t          status_o,
  output logic [lpsis_pkg::TotalW-1:0]   interior_total_o,
  output logic                           saturated_o
);

  localparam int unsigned CW = lpsis_pkg::CoordBits;

  lpsis_pkg::vertex_t wdata, rdata;
  lpsis_pkg::vertex_t prev_q, cur_q, next_q, first_q, last_q, ep_q, eq_q;
  logic                             have_first_q;
  logic signed [CW:0]               ux, uy, vx, vy;
  logic signed [lpsis_pkg::CrossW-1:0] cross_a_q, cross_b_q;
  logic [lpsis_pkg::ProdW-1:0]      pa_q, pb_q;
  logic [lpsis_pkg::AreaW-1:0]      area_q, area_abs;
  logic [lpsis_pkg::BndW-1:0]       bnd_q, b_q;
  logic [lpsis_pkg::GcdW-1:0]       g_q, gcd_a, gcd_b, gcd_res;
  logic [2*lpsis_pkg::GcdW-1:0]     gsq_q;
  logic                             gcd_start, gcd_done;
  logic                             div_start, div_done;
  logic [lpsis_pkg::DivW-1:0]       div_dvd, div_dvs, quot;
  logic [lpsis_pkg::DivW-1:0]       a2_q;
  logic [lpsis_pkg::ScaleW-1:0]     scale_q, s_q;
  logic [lpsis_pkg::QW-1:0]         q_q, dq_q, diff_q, a2_w;
  logic [lpsis_pkg::TW-1:0]         t_q;
  logic                             neg_q;
  logic [lpsis_pkg::SumW-1:0]       term_q, sum_q;
  logic [CW-1:0]                    dx, dy;
  logic                             over;
  logic [lpsis_pkg::TotalW-1:0]     total_q;
  logic                             sat_q;

  assign wdata.x = CW'(x_coord_i);
  assign wdata.y = CW'(y_coord_i);

  lpsis_ram #(
    .Width(lpsis_pkg::VtxW),
    .Depth(lpsis_pkg::MaxVertices)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_en),
    .waddr_i(cmd_i.wr_addr),
    .wdata_i(wdata),
    .re_i   (cmd_i.rd_en),
    .raddr_i(cmd_i.rd_addr),
    .rdata_o(rdata)
  );

  assign ux = $signed({1'b0, cur_q.x}) - $signed({1'b0, next_q.x});
  assign uy = $signed({1'b0, cur_q.y}) - $signed({1'b0, next_q.y});
  assign vx = $signed({1'b0, cur_q.x}) - $signed({1'b0, prev_q.x});
  assign vy = $signed({1'b0, cur_q.y}) - $signed({1'b0, prev_q.y});

  assign dx = (ep_q.x >= eq_q.x) ? ep_q.x - eq_q.x : eq_q.x - ep_q.x;
  assign dy = (ep_q.y >= eq_q.y) ? ep_q.y - eq_q.y : eq_q.y - ep_q.y;

  assign gcd_start = (cmd_i.op == lpsis_pkg::OP_EACC) || (cmd_i.op == lpsis_pkg::OP_BND);
  assign gcd_a     = (cmd_i.op == lpsis_pkg::OP_EACC) ? lpsis_pkg::GcdW'(dx) : g_q;
  assign gcd_b     = (cmd_i.op == lpsis_pkg::OP_EACC) ? lpsis_pkg::GcdW'(dy) : gcd_res;

  lpsis_gcd u_gcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (gcd_start),
    .a_i     (gcd_a),
    .b_i     (gcd_b),
    .done_o  (gcd_done),
    .result_o(gcd_res)
  );

  assign area_abs  = area_q[lpsis_pkg::AreaW-1] ? '0 - area_q : area_q;
  assign div_start = (cmd_i.op == lpsis_pkg::OP_DIVA) || (cmd_i.op == lpsis_pkg::OP_A2);
  assign div_dvd   = (cmd_i.op == lpsis_pkg::OP_DIVA) ? lpsis_pkg::DivW'(area_abs)
                                                      : lpsis_pkg::DivW'(bnd_q);
  assign div_dvs   = (cmd_i.op == lpsis_pkg::OP_DIVA) ? lpsis_pkg::DivW'(gsq_q)
                                                      : lpsis_pkg::DivW'(g_q);

  lpsis_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dvd),
    .divisor_i (div_dvs),
    .done_o    (div_done),
    .quotient_o(quot)
  );

  assign a2_w = lpsis_pkg::QW'(a2_q);
  assign over = |sum_q[lpsis_pkg::SumW-2:lpsis_pkg::TotalW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_first_q <= 1'b0;
    end else if (cmd_i.op == lpsis_pkg::OP_CLEAR) begin
      have_first_q <= 1'b0;
    end else if (cmd_i.op == lpsis_pkg::OP_KEEP && cross_a_q != cross_b_q) begin
      have_first_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_last) begin
      scale_q <= scale_count_i;
    end
    unique case (cmd_i.op)
      lpsis_pkg::OP_CLEAR: begin
        area_q <= '0;
        bnd_q  <= '0;
        g_q    <= '0;
        sum_q  <= '0;
      end
      lpsis_pkg::OP_SHIFT: begin
        prev_q <= cur_q;
        cur_q  <= next_q;
        next_q <= rdata;
      end
      lpsis_pkg::OP_CROSS: begin
        cross_a_q <= ux * vy;
        cross_b_q <= uy * vx;
      end
      lpsis_pkg::OP_KEEP: begin
        if (cross_a_q != cross_b_q) begin
          if (!have_first_q) begin
            first_q <= cur_q;
            last_q  <= cur_q;
          end else begin
            ep_q <= last_q;
            eq_q <= cur_q;
          end
        end
      end
      lpsis_pkg::OP_CLOSE: begin
        ep_q <= last_q;
        eq_q <= first_q;
      end
      lpsis_pkg::OP_EMUL: begin
        pa_q <= ep_q.x * eq_q.y;
        pb_q <= ep_q.y * eq_q.x;
      end
      lpsis_pkg::OP_EACC: begin
        area_q <= area_q + lpsis_pkg::AreaW'(pa_q) - lpsis_pkg::AreaW'(pb_q);
      end
      lpsis_pkg::OP_BND: begin
        bnd_q <= bnd_q + lpsis_pkg::BndW'(gcd_res);
      end
      lpsis_pkg::OP_GSTORE: begin
        g_q    <= gcd_res;
        last_q <= eq_q;
      end
      lpsis_pkg::OP_SQ: begin
        gsq_q <= g_q * g_q;
      end
      lpsis_pkg::OP_A2: begin
        a2_q <= quot;
      end
      lpsis_pkg::OP_B: begin
        b_q <= lpsis_pkg::BndW'(quot);
      end
      lpsis_pkg::OP_SINIT: begin
        q_q  <= a2_w;
        dq_q <= a2_w + (a2_w << 1);
        t_q  <= lpsis_pkg::TW'(b_q);
        s_q  <= lpsis_pkg::ScaleW'(1);
      end
      lpsis_pkg::OP_S1: begin
        neg_q  <= q_q < lpsis_pkg::QW'(t_q);
        diff_q <= (q_q >= lpsis_pkg::QW'(t_q)) ? q_q - lpsis_pkg::QW'(t_q)
                                               : lpsis_pkg::QW'(t_q) - q_q;
      end
      lpsis_pkg::OP_S2: begin
        term_q <= neg_q ? lpsis_pkg::SumW'(1) - lpsis_pkg::SumW'(diff_q >> 1)
                        : lpsis_pkg::SumW'(diff_q >> 1) + lpsis_pkg::SumW'(1);
      end
      lpsis_pkg::OP_S3: begin
        sum_q <= sum_q + term_q;
        q_q   <= q_q + dq_q;
        dq_q  <= dq_q + (a2_w << 1);
        t_q   <= t_q + lpsis_pkg::TW'(b_q);
        s_q   <= s_q + 1'b1;
      end
      lpsis_pkg::OP_OUT: begin
        sat_q <= sum_q[lpsis_pkg::SumW-1] | over;
        priority if (sum_q[lpsis_pkg::SumW-1]) begin
          total_q <= '0;
        end else if (over) begin
          total_q <= '1;
        end else begin
          total_q <= sum_q[lpsis_pkg::TotalW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  assign status_o.keep       = cross_a_q != cross_b_q;
  assign status_o.have_first = have_first_q;
  assign status_o.g_zero     = g_q == '0;
  assign status_o.gcd_done   = gcd_done;
  assign status_o.div_done   = div_done;
  assign status_o.last_scale = s_q == scale_q;
  assign status_o.scale_zero = scale_q == '0;

  assign interior_total_o = total_q;
  assign saturated_o      = sat_q;

endmodule

### rtl/core/lpsis_ctrl.sv
// Controller: vertex loading, read sequencing over the store, and pass sequencing.
// Depends on lpsis_pkg.
module lpsis_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  last_vertex_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  lpsis_pkg::dp_status_t status_i,
  output lpsis_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [21:0] {
    S_IDLE  = 22'h000001,
    S_INIT  = 22'h000002,
    S_RD    = 22'h000004,
    S_CAP   = 22'h000008,
    S_CROSS = 22'h000010,
    S_TEST  = 22'h000020,
    S_ADV   = 22'h000040,
    S_EMUL  = 22'h000080,
    S_EACC  = 22'h000100,
    S_GCD1  = 22'h000200,
    S_GCD2  = 22'h000400,
    S_FIN   = 22'h000800,
    S_DA0   = 22'h001000,
    S_DA    = 22'h002000,
    S_DB    = 22'h004000,
    S_SINIT = 22'h008000,
    S_SUM1  = 22'h010000,
    S_SUM2  = 22'h020000,
    S_SUM3  = 22'h040000,
    S_DONE  = 22'h080000,
    S_SPARE = 22'h100000,
    S_HOLD  = 22'h200000
  } state_e;

  state_e                        state_q, state_d;
  logic [lpsis_pkg::CntW-1:0]    cnt_q, cnt_d;
  logic [lpsis_pkg::IdxW-1:0]    j_q, j_d, n_ext;
  logic                          closing_q, closing_d;
  logic                          out_valid_q, out_valid_d;
  logic                          accept, not_full;

  assign accept   = in_valid_i && in_ready_o;
  assign not_full = cnt_q < lpsis_pkg::CntW'(lpsis_pkg::MaxVertices);
  assign n_ext    = lpsis_pkg::IdxW'(cnt_q);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    j_d         = j_q;
    closing_d   = closing_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    cmd_o.op    = lpsis_pkg::OP_NONE;
    cmd_o.wr_addr = lpsis_pkg::AddrW'(cnt_q);
    priority if (j_q == '0) begin
      cmd_o.rd_addr = lpsis_pkg::AddrW'(cnt_q - 1'b1);
    end else if (j_q == n_ext + 1'b1) begin
      cmd_o.rd_addr = '0;
    end else begin
      cmd_o.rd_addr = lpsis_pkg::AddrW'(j_q - 1'b1);
    end
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (accept) begin
          cmd_o.wr_en = not_full;
          if (not_full) begin
            cnt_d = cnt_q + 1'b1;
          end
          if (last_vertex_i) begin
            cmd_o.take_last = 1'b1;
            state_d         = S_INIT;
          end
        end
      end
      S_INIT: begin
        cmd_o.op  = lpsis_pkg::OP_CLEAR;
        j_d       = '0;
        closing_d = 1'b0;
        state_d   = (cnt_q == '0) ? S_DONE : S_RD;
      end
      S_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_CAP;
      end
      S_CAP: begin
        cmd_o.op = lpsis_pkg::OP_SHIFT;
        j_d      = j_q + 1'b1;
        state_d  = (j_q >= lpsis_pkg::IdxW'(2)) ? S_CROSS : S_RD;
      end
      S_CROSS: begin
        cmd_o.op = lpsis_pkg::OP_CROSS;
        state_d  = S_TEST;
      end
      S_TEST: begin
        cmd_o.op = lpsis_pkg::OP_KEEP;
        state_d  = (status_i.keep && status_i.have_first) ? S_EMUL : S_ADV;
      end
      S_ADV: begin
        if (j_q == n_ext + lpsis_pkg::IdxW'(2)) begin
          if (status_i.have_first) begin
            cmd_o.op  = lpsis_pkg::OP_CLOSE;
            closing_d = 1'b1;
            state_d   = S_EMUL;
          end else begin
            state_d = S_DONE;
          end
        end else begin
          state_d = S_RD;
        end
      end
      S_EMUL: begin
        cmd_o.op = lpsis_pkg::OP_EMUL;
        state_d  = S_EACC;
      end
      S_EACC: begin
        cmd_o.op = lpsis_pkg::OP_EACC;
        state_d  = S_GCD1;
      end
      S_GCD1: begin
        if (status_i.gcd_done) begin
          cmd_o.op = lpsis_pkg::OP_BND;
          state_d  = S_GCD2;
        end
      end
      S_GCD2: begin
        if (status_i.gcd_done) begin
          cmd_o.op = lpsis_pkg::OP_GSTORE;
          state_d  = closing_q ? S_FIN : S_ADV;
        end
      end
      S_FIN: begin
        if (status_i.g_zero) begin
          state_d = S_DONE;
        end else begin
          cmd_o.op = lpsis_pkg::OP_SQ;
          state_d  = S_DA0;
        end
      end
      S_DA0: begin
        cmd_o.op = lpsis_pkg::OP_DIVA;
        state_d  = S_DA;
      end
      S_DA: begin
        if (status_i.div_done) begin
          cmd_o.op = lpsis_pkg::OP_A2;
          state_d  = S_DB;
        end
      end
      S_DB: begin
        if (status_i.div_done) begin
          cmd_o.op = lpsis_pkg::OP_B;
          state_d  = S_SINIT;
        end
      end
      S_SINIT: begin
        if (status_i.scale_zero) begin
          state_d = S_DONE;
        end else begin
          cmd_o.op = lpsis_pkg::OP_SINIT;
          state_d  = S_SUM1;
        end
      end
      S_SUM1: begin
        cmd_o.op = lpsis_pkg::OP_S1;
        state_d  = S_SUM2;
      end
      S_SUM2: begin
        cmd_o.op = lpsis_pkg::OP_S2;
        state_d  = S_SUM3;
      end
      S_SUM3: begin
        cmd_o.op = lpsis_pkg::OP_S3;
        state_d  = status_i.last_scale ? S_DONE : S_SUM1;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = lpsis_pkg::OP_OUT;
          out_valid_d = 1'b1;
          cnt_d       = '0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      j_q         <= '0;
      closing_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      j_q         <= j_d;
      closing_q   <= closing_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_rd_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_en |-> cnt_q != '0)
    else $error("store read with no vertices loaded");

  a_last_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && last_vertex_i |=> state_q == S_INIT)
    else $error("closing vertex did not start the pass");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RD |-> j_q <= n_ext + 1'b1)
    else $error("read index past the closing wrap");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result raised outside the done state");

endmodule

### rtl/core/lattice_polygon_scaled_interior_sum.sv
// Top level of the scaled polygon interior lattice point sum.
// Depends on lpsis_pkg, lpsis_ctrl, lpsis_dp.
//
//   channel | signals                                              | direction
//   in      | in_valid_i/in_ready_o, x_coord_i, y_coord_i,         | sink
//           | scale_count_i, last_vertex_i                         |
//   out     | out_valid_o/out_ready_i, interior_total_o, saturated_o | source
//
// The closing vertex starts a pass over the stored vertices, with two binary gcd
// runs per kept vertex, then the two divisions, then the sum steps S1, S2, S3 per scale.
// Reset clears the vertex count and control; no clearing pass is run.
// A pending result holds while out_ready_i is low; vertices are still taken.
module lattice_polygon_scaled_interior_sum (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [lpsis_pkg::InCoordW-1:0] x_coord_i,
  input  logic [lpsis_pkg::InCoordW-1:0] y_coord_i,
  input  logic [lpsis_pkg::ScaleW-1:0]   scale_count_i,
  input  logic                           last_vertex_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [lpsis_pkg::TotalW-1:0]   interior_total_o,
  output logic                           saturated_o
);

  lpsis_pkg::ctrl_cmd_t  cmd;
  lpsis_pkg::dp_status_t status;

  lpsis_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .last_vertex_i(last_vertex_i),
    .in_ready_o   (in_ready_o),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  lpsis_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .x_coord_i       (x_coord_i),
    .y_coord_i       (y_coord_i),
    .scale_count_i   (scale_count_i),
    .status_o        (status),
    .interior_total_o(interior_total_o),
    .saturated_o     (saturated_o)
  );

endmodule
